// ===== rtl/ics_pkg.sv =====
package ics_pkg;

    localparam int MAX_INTERVALS = 1024;
    localparam int POS_W         = 32;
    localparam int DEPTH_W       = 12;
    localparam int SLOTS         = 2 * MAX_INTERVALS;
    localparam int ADDR_W        = $clog2(SLOTS);
    localparam int IDX_W         = ADDR_W + 1;
    localparam int SORT_W        = ADDR_W + 2;
    localparam int EV_W          = POS_W + 1;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_LOAD_FULL,
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_SORT_INIT,
        CMD_BLK_INIT,
        CMD_RD_A,
        CMD_CAP_A,
        CMD_RD_B,
        CMD_CAP_B,
        CMD_TAKE_A,
        CMD_TAKE_B,
        CMD_BLK_NEXT,
        CMD_PASS_NEXT,
        CMD_SWEEP_INIT,
        CMD_RD_IDX,
        CMD_EVAL,
        CMD_LOOK_INIT,
        CMD_RD_LOOK,
        CMD_LOOK_EVAL,
        CMD_FINISH,
        CMD_EMIT
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_LOAD_B,
        S_PASS,
        S_BLK,
        S_RDA0,
        S_CAPA0,
        S_RDA,
        S_CAPA,
        S_RDB,
        S_CAPB,
        S_CMP,
        S_SWEEP_RD,
        S_SWEEP_EV,
        S_LOOK,
        S_LOOK_RD,
        S_LOOK_EV,
        S_FINISH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic op;
        logic sorted;
        logic full;
        logic w_lt_cnt;
        logic base_lt_cnt;
        logic j_lt_je;
        logic take_a;
        logic sweep_go;
        logic ev_over;
        logic ev_same;
        logic look_go;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/interval_coverage_sweep.sv =====
// Interval coverage sweep. A load request (op 0) stores two events unless
// the store is full or sorted; a fetch request (op 1) returns one coverage
// run. The first fetch of a group runs a merge sort over the event store
// held in two ping-pong memories: ceil(log2(N)) passes, with N the number
// of stored events. Each fetch then runs the sweep and its look-ahead. A
// new request is taken once the previous one has been placed in the output
// register.
module interval_coverage_sweep import ics_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_op,
    input  logic [31:0]               i_interval_start,
    input  logic [31:0]               i_interval_end,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [31:0]               o_run_start,
    output logic [31:0]               o_run_end,
    output logic signed [DEPTH_W-1:0] o_run_depth,
    output logic                      o_run_valid,
    output logic                      o_last_run,
    output logic                      o_store_full,
    output logic                      o_out_of_bounds,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [31:0]               i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ics_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    ics_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_op             (i_op),
        .i_interval_start (i_interval_start),
        .i_interval_end   (i_interval_end),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_out_ready),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .o_run_start      (o_run_start),
        .o_run_end        (o_run_end),
        .o_run_depth      (o_run_depth),
        .o_run_valid      (o_run_valid),
        .o_last_run       (o_last_run),
        .o_store_full     (o_store_full),
        .o_out_of_bounds  (o_out_of_bounds)
    );

endmodule

// ===== rtl/ics_ram.sv =====
module ics_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ics_datapath.sv =====
module ics_datapath import ics_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic                      i_op,
    input  logic [31:0]               i_interval_start,
    input  logic [31:0]               i_interval_end,
    input  logic                      i_cfg_valid,
    input  logic [31:0]               i_cfg_data,
    input  logic                      i_out_ready,
    output t_status                   o_status,
    output logic                      o_out_valid,
    output logic [31:0]               o_run_start,
    output logic [31:0]               o_run_end,
    output logic signed [DEPTH_W-1:0] o_run_depth,
    output logic                      o_run_valid,
    output logic                      o_last_run,
    output logic                      o_store_full,
    output logic                      o_out_of_bounds
);

    logic               r_op;
    logic [POS_W-1:0]   r_start, r_end, r_chrom;
    logic [IDX_W-1:0]   r_cnt, r_idx, r_look;
    logic               r_sorted, r_bounds, r_sel, r_more;
    logic [POS_W-1:0]   r_prev, r_lee;
    logic [DEPTH_W-1:0] r_depth;
    logic [SORT_W-1:0]  r_w, r_base, r_i, r_ie, r_j, r_je, r_k;
    logic [EV_W-1:0]    r_ha, r_hb;
    logic [POS_W-1:0]   r_rs, r_re;
    logic [DEPTH_W-1:0] r_rd;
    logic               r_valid, r_last, r_full, r_oob;
    logic               r_out_valid;
    logic [POS_W-1:0]   r_o_rs, r_o_re;
    logic [DEPTH_W-1:0] r_o_rd;
    logic               r_o_valid, r_o_last, r_o_full, r_o_oob;

    logic [ADDR_W-1:0]  raddr, waddr;
    logic [EV_W-1:0]    wdata, rd0, rd1, rdata;
    logic               we, bank;
    logic [POS_W-1:0]   ev_pos;
    logic               ev_up;
    logic [DEPTH_W-1:0] depth_step;
    logic [SORT_W-1:0]  cnt_x, mid_sum, end_sum, n_ie, n_je;
    logic [IDX_W-1:0]   cnt_p1;

    assign rdata  = r_sel ? rd1 : rd0;
    assign ev_pos = rdata[EV_W-1:1];
    assign ev_up  = rdata[0];
    assign depth_step = r_depth + (ev_up ? DEPTH_W'(1) : {DEPTH_W{1'b1}});
    assign cnt_x   = SORT_W'(r_cnt);
    assign cnt_p1  = r_cnt + IDX_W'(1);
    assign mid_sum = r_base + r_w;
    assign end_sum = r_base + (r_w << 1);
    assign n_ie    = (mid_sum < cnt_x) ? mid_sum : cnt_x;
    assign n_je    = (end_sum < cnt_x) ? end_sum : cnt_x;

    always_comb begin
        case (i_cmd)
            CMD_RD_A:    raddr = r_i[ADDR_W-1:0];
            CMD_RD_B:    raddr = r_j[ADDR_W-1:0];
            CMD_RD_LOOK: raddr = r_look[ADDR_W-1:0];
            default:     raddr = r_idx[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        we    = 1'b0;
        bank  = ~r_sel;
        waddr = r_k[ADDR_W-1:0];
        wdata = r_ha;
        case (i_cmd)
            CMD_LOAD_A: begin
                we    = 1'b1;
                bank  = r_sel;
                waddr = r_cnt[ADDR_W-1:0];
                wdata = {r_start, 1'b1};
            end
            CMD_LOAD_B: begin
                we    = 1'b1;
                bank  = r_sel;
                waddr = cnt_p1[ADDR_W-1:0];
                wdata = {r_end, 1'b0};
            end
            CMD_TAKE_A: we = 1'b1;
            CMD_TAKE_B: begin
                we    = 1'b1;
                wdata = r_hb;
            end
            default: we = 1'b0;
        endcase
    end

    ics_ram #(.WIDTH(EV_W), .DEPTH(SLOTS)) u_ram0 (
        .i_clk   (i_clk),
        .i_we    (we & ~bank),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd0)
    );

    ics_ram #(.WIDTH(EV_W), .DEPTH(SLOTS)) u_ram1 (
        .i_clk   (i_clk),
        .i_we    (we & bank),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chrom     <= '0;
            r_cnt       <= '0;
            r_sorted    <= 1'b0;
            r_idx       <= '0;
            r_prev      <= '0;
            r_depth     <= '0;
            r_lee       <= '0;
            r_bounds    <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_chrom <= i_cfg_data;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                CMD_CAPTURE: begin
                    r_op    <= i_op;
                    r_start <= i_interval_start;
                    r_end   <= i_interval_end;
                    r_rs    <= '0;
                    r_re    <= '0;
                    r_rd    <= '0;
                    r_valid <= 1'b0;
                    r_last  <= 1'b0;
                    r_full  <= 1'b0;
                    r_oob   <= 1'b0;
                    r_more  <= 1'b0;
                end
                CMD_LOAD_FULL: r_full <= 1'b1;
                CMD_LOAD_B:    r_cnt  <= r_cnt + IDX_W'(2);
                CMD_SORT_INIT: begin
                    r_w    <= SORT_W'(1);
                    r_base <= '0;
                end
                CMD_BLK_INIT: begin
                    r_i  <= r_base;
                    r_ie <= n_ie;
                    r_j  <= n_ie;
                    r_je <= n_je;
                    r_k  <= r_base;
                end
                CMD_CAP_A: r_ha <= rdata;
                CMD_CAP_B: r_hb <= rdata;
                CMD_TAKE_A: begin
                    r_i <= r_i + SORT_W'(1);
                    r_k <= r_k + SORT_W'(1);
                end
                CMD_TAKE_B: begin
                    r_j <= r_j + SORT_W'(1);
                    r_k <= r_k + SORT_W'(1);
                end
                CMD_BLK_NEXT: r_base <= end_sum;
                CMD_PASS_NEXT: begin
                    r_w    <= r_w << 1;
                    r_sel  <= ~r_sel;
                    r_base <= '0;
                end
                CMD_SWEEP_INIT: begin
                    r_sorted <= 1'b1;
                    r_idx    <= '0;
                    r_prev   <= '0;
                    r_depth  <= '0;
                    r_lee    <= '0;
                end
                CMD_EVAL: begin
                    if (ev_pos > r_chrom) begin
                        r_bounds <= 1'b1;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_depth <= depth_step;
                        if (ev_pos != r_prev) begin
                            r_rs    <= r_prev;
                            r_re    <= ev_pos;
                            r_rd    <= r_depth;
                            r_prev  <= ev_pos;
                            r_lee   <= ev_pos;
                            r_valid <= 1'b1;
                        end
                    end
                end
                CMD_LOOK_INIT: r_look <= r_idx;
                CMD_LOOK_EVAL: begin
                    if (ev_pos == r_prev) begin
                        r_look <= r_look + IDX_W'(1);
                    end else if (ev_pos > r_chrom) begin
                        r_bounds <= 1'b1;
                    end else begin
                        r_more <= 1'b1;
                    end
                end
                CMD_FINISH: begin
                    r_oob <= r_bounds;
                    if (r_valid) begin
                        r_last <= !r_more && (r_lee >= r_chrom);
                    end else begin
                        r_last <= 1'b1;
                        if (r_lee < r_chrom) begin
                            r_rs    <= r_lee;
                            r_re    <= r_chrom;
                            r_rd    <= '0;
                            r_valid <= 1'b1;
                        end
                    end
                end
                CMD_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_o_rs      <= r_rs;
                    r_o_re      <= r_re;
                    r_o_rd      <= r_rd;
                    r_o_valid   <= r_valid;
                    r_o_last    <= r_last;
                    r_o_full    <= r_full;
                    r_o_oob     <= r_oob;
                    if (r_last) begin
                        r_cnt    <= '0;
                        r_sorted <= 1'b0;
                        r_idx    <= '0;
                        r_prev   <= '0;
                        r_depth  <= '0;
                        r_lee    <= '0;
                        r_bounds <= 1'b0;
                        r_sel    <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_status.op          = r_op;
        o_status.sorted      = r_sorted;
        o_status.full        = r_cnt > IDX_W'(SLOTS - 2);
        o_status.w_lt_cnt    = r_w < cnt_x;
        o_status.base_lt_cnt = r_base < cnt_x;
        o_status.j_lt_je     = r_j < r_je;
        o_status.take_a      = (r_i < r_ie) && (!(r_j < r_je) || !(r_hb < r_ha));
        o_status.sweep_go    = !r_bounds && (r_idx < r_cnt);
        o_status.ev_over     = ev_pos > r_chrom;
        o_status.ev_same     = ev_pos == r_prev;
        o_status.look_go     = r_look < r_cnt;
        o_status.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_run_start     = r_o_rs;
    assign o_run_end       = r_o_re;
    assign o_run_depth     = r_o_rd;
    assign o_run_valid     = r_o_valid;
    assign o_last_run      = r_o_last;
    assign o_store_full    = r_o_full;
    assign o_out_of_bounds = r_o_oob;

endmodule

// ===== rtl/ics_ctrl.sv =====
module ics_ctrl import ics_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_DECODE;
            S_DECODE: begin
                if (!i_status.op) begin
                    if (i_status.sorted || i_status.full) n_state = S_EMIT;
                    else                                  n_state = S_LOAD_B;
                end else begin
                    n_state = i_status.sorted ? S_SWEEP_RD : S_PASS;
                end
            end
            S_LOAD_B:   n_state = S_EMIT;
            S_PASS:     n_state = i_status.w_lt_cnt ? S_BLK : S_SWEEP_RD;
            S_BLK:      n_state = i_status.base_lt_cnt ? S_RDA0 : S_PASS;
            S_RDA0:     n_state = S_CAPA0;
            S_CAPA0:    n_state = S_RDB;
            S_RDA:      n_state = S_CAPA;
            S_CAPA:     n_state = S_CMP;
            S_RDB:      n_state = S_CAPB;
            S_CAPB:     n_state = S_CMP;
            S_CMP: begin
                if (i_status.take_a)       n_state = S_RDA;
                else if (i_status.j_lt_je) n_state = S_RDB;
                else                       n_state = S_BLK;
            end
            S_SWEEP_RD: n_state = i_status.sweep_go ? S_SWEEP_EV : S_FINISH;
            S_SWEEP_EV: begin
                if (i_status.ev_over)      n_state = S_FINISH;
                else if (i_status.ev_same) n_state = S_SWEEP_RD;
                else                       n_state = S_LOOK;
            end
            S_LOOK:     n_state = S_LOOK_RD;
            S_LOOK_RD:  n_state = i_status.look_go ? S_LOOK_EV : S_FINISH;
            S_LOOK_EV:  n_state = i_status.ev_same ? S_LOOK_RD : S_FINISH;
            S_FINISH:   n_state = S_EMIT;
            S_EMIT:     if (i_status.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = CMD_CAPTURE;
            end
            S_DECODE: begin
                if (!i_status.op) begin
                    if (i_status.sorted)    o_cmd = CMD_NONE;
                    else if (i_status.full) o_cmd = CMD_LOAD_FULL;
                    else                    o_cmd = CMD_LOAD_A;
                end else if (!i_status.sorted) begin
                    o_cmd = CMD_SORT_INIT;
                end
            end
            S_LOAD_B:   o_cmd = CMD_LOAD_B;
            S_PASS:     o_cmd = i_status.w_lt_cnt ? CMD_NONE : CMD_SWEEP_INIT;
            S_BLK:      o_cmd = i_status.base_lt_cnt ? CMD_BLK_INIT : CMD_PASS_NEXT;
            S_RDA0:     o_cmd = CMD_RD_A;
            S_CAPA0:    o_cmd = CMD_CAP_A;
            S_RDA:      o_cmd = CMD_RD_A;
            S_CAPA:     o_cmd = CMD_CAP_A;
            S_RDB:      o_cmd = CMD_RD_B;
            S_CAPB:     o_cmd = CMD_CAP_B;
            S_CMP: begin
                if (i_status.take_a)       o_cmd = CMD_TAKE_A;
                else if (i_status.j_lt_je) o_cmd = CMD_TAKE_B;
                else                       o_cmd = CMD_BLK_NEXT;
            end
            S_SWEEP_RD: if (i_status.sweep_go) o_cmd = CMD_RD_IDX;
            S_SWEEP_EV: o_cmd = CMD_EVAL;
            S_LOOK:     o_cmd = CMD_LOOK_INIT;
            S_LOOK_RD:  if (i_status.look_go) o_cmd = CMD_RD_LOOK;
            S_LOOK_EV:  o_cmd = CMD_LOOK_EVAL;
            S_FINISH:   o_cmd = CMD_FINISH;
            S_EMIT:     if (i_status.out_free) o_cmd = CMD_EMIT;
            default:    o_cmd = CMD_NONE;
        endcase
    end

endmodule
